/* design/r2fft_pkg.sv */
package r2fft_pkg;

	localparam int MAX_LOG_LEN = 10;
	localparam int TW_FRAC     = 15;
	localparam int FRAME_MAX   = 1 << MAX_LOG_LEN;
	localparam int ROM_LEN     = FRAME_MAX / 2;
	localparam int ADDR_W      = MAX_LOG_LEN;
	localparam int CNT_W       = MAX_LOG_LEN + 1;
	localparam int ROM_AW      = MAX_LOG_LEN - 1;
	localparam int LG_W        = 4;
	localparam int SAMPLE_W    = 16;
	localparam int ACC_W       = 32;
	localparam int TW_W        = TW_FRAC + 2;
	localparam int PROD_W      = TW_W + ACC_W;
	localparam int BATCH_W     = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG_LEN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_HALVES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_FRAMES = 2'd3;

	typedef logic signed [TW_W-1:0] tw_t;
	typedef tw_t tw_rom_t [ROM_LEN];

	// queue entry between front and back
	typedef struct packed {
		logic                       is_read;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_OUT,
		ST_XF_NEXT,
		ST_XF_RD_P,
		ST_XF_RD_Q,
		ST_XF_MUL,
		ST_XF_RND,
		ST_XF_WR_P,
		ST_XF_WR_Q
	} state_t;

	typedef enum logic [1:0] {
		PH_PRESWAP,
		PH_BITREV,
		PH_STAGE,
		PH_POSTSWAP
	} phase_t;

	// Twiddle table: Q30 Taylor series on angle folded into [0, pi/4], rounded half up.
	function automatic tw_rom_t build_rom(input bit want_sin);
		tw_rom_t rom;
		longint unsigned kk, x, x2, ts, tc;
		longint ss, cs, v, cv, sv;
		bit neg, swp;
		for (int k = 0; k < ROM_LEN; k++) begin
			kk  = longint'(k);
			neg = 1'b0;
			swp = 1'b0;
			if (kk > longint'(FRAME_MAX / 4)) begin
				kk  = longint'(FRAME_MAX / 2) - kk;
				neg = 1'b1;
			end
			if (kk > longint'(FRAME_MAX / 8)) begin
				kk  = longint'(FRAME_MAX / 4) - kk;
				swp = 1'b1;
			end
			x  = (kk * (64'hC90FDAA22168C234 >> 22) + (64'd1 << (MAX_LOG_LEN + 8)))
			     >> (MAX_LOG_LEN + 9);
			x2 = (x * x) >> 30;
			ts = x;
			tc = 64'd1 << 30;
			ss = longint'(x);
			cs = longint'(64'd1 << 30);
			for (int i = 1; i <= 7; i++) begin
				ts = ((ts * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
				tc = ((tc * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
				if ((i % 2) == 1) begin
					ss = ss - longint'(ts);
					cs = cs - longint'(tc);
				end else begin
					ss = ss + longint'(ts);
					cs = cs + longint'(tc);
				end
			end
			v = swp ? ss : cs;
			if (v < 0) v = 0;
			if (v > (longint'(1) << 30)) v = longint'(1) << 30;
			cv = (v + (longint'(1) << (29 - TW_FRAC))) >>> (30 - TW_FRAC);
			v = swp ? cs : ss;
			if (v < 0) v = 0;
			if (v > (longint'(1) << 30)) v = longint'(1) << 30;
			sv = (v + (longint'(1) << (29 - TW_FRAC))) >>> (30 - TW_FRAC);
			if (want_sin) rom[k] = tw_t'(sv);
			else          rom[k] = neg ? tw_t'(-cv) : tw_t'(cv);
		end
		return rom;
	endfunction

	localparam tw_rom_t ROM_COS = build_rom(1'b0);
	localparam tw_rom_t ROM_SIN = build_rom(1'b1);

endpackage

/* design/r2fft_if.sv */
interface r2fft_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 mode;
	logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real;
	logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag;
	modport source (output valid, mode, sample_real, sample_imag, input ready);
	modport sink (input valid, mode, sample_real, sample_imag, output ready);
endinterface

interface r2fft_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [r2fft_pkg::ACC_W-1:0] result_real;
	logic signed [r2fft_pkg::ACC_W-1:0] result_imag;
	logic                              last_in_frame;
	logic                              last_in_batch;
	logic                              no_data;
	modport source (output valid, result_real, result_imag, last_in_frame, last_in_batch,
		no_data, input ready);
	modport sink (input valid, result_real, result_imag, last_in_frame, last_in_batch,
		no_data, output ready);
endinterface

interface r2fft_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [r2fft_pkg::CFG_IDX_W-1:0]      index;
	logic [r2fft_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/r2fft_front.sv */
module r2fft_front (
	input  logic              clk,
	input  logic              arst_n,
	r2fft_in_if.sink          in_ch,
	output logic              q_valid,
	output r2fft_pkg::item_t  q_item,
	input  logic              q_pop
);

	// two-word queue; mode decoded into the entry's op flag
	r2fft_pkg::item_t item_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (count_q != 2'd0);
	assign q_item      = item_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop) count_q <= count_q + 2'd1;
			else if (!push && q_pop) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q].is_read <= in_ch.mode;
			item_q[wr_ptr_q].re      <= in_ch.sample_real;
			item_q[wr_ptr_q].im      <= in_ch.sample_imag;
		end
	end

endmodule

/* design/r2fft_engine.sv */
module r2fft_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  r2fft_pkg::item_t q_item,
	output logic             q_pop,
	r2fft_cfg_if.sink        cfg,
	r2fft_out_if.source      out_ch
);

	localparam int AW = r2fft_pkg::ADDR_W;
	localparam int CW = r2fft_pkg::CNT_W;
	localparam int DW = r2fft_pkg::ACC_W;

	r2fft_pkg::state_t state_q, state_d;
	r2fft_pkg::phase_t phase_q;

	// config
	logic [r2fft_pkg::LG_W-1:0]    log_len_q;
	logic                          inverse_q, shift_q;
	logic [r2fft_pkg::BATCH_W-1:0] batch_q;

	logic [AW-1:0] load_idx_q, read_idx_q;
	logic [r2fft_pkg::BATCH_W-1:0] frame_cnt_q;
	logic          frame_ready_q;
	logic [r2fft_pkg::LG_W-1:0] stage_q;
	logic [CW-1:0] cnt_q;

	// pair / butterfly payload
	logic [AW-1:0] p_q, q_q;
	logic          bfly_q;
	r2fft_pkg::tw_t wr_q, wi_q;
	logic [DW-1:0] xp_re_q, xp_im_q, z_re_q, z_im_q, t_re_q, t_im_q;
	logic signed [r2fft_pkg::PROD_W-1:0] prr_q, pii_q, pri_q, pir_q;

	// output register
	logic          out_valid_q;
	logic [DW-1:0] res_re_q, res_im_q;
	logic          lf_q, lb_q, nd_q;

	// memory
	logic [2*DW-1:0] mem [r2fft_pkg::FRAME_MAX];
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [2*DW-1:0] wdata, rdata_q;

	// derived
	logic [r2fft_pkg::LG_W-1:0] lg;
	logic [CW-1:0] n_w, half_w, limit;
	logic          last_load, out_free, post_needed, at_limit, xf_done;
	logic          out_load_nd, out_load_data, rd_last_frame, rd_last_batch;
	logic [r2fft_pkg::BATCH_W-1:0] batch_eff;

	// pair generator
	logic [AW-1:0] cnt_a, rev_full, rev_sh, span, a_off, grp, pair_p, pair_q;
	logic [AW-1:0] k_full;
	logic [r2fft_pkg::ROM_AW-1:0] k;
	logic          active;
	logic signed [r2fft_pkg::PROD_W:0] sum_re, sum_im;

	always_comb begin
		if (log_len_q == '0) lg = r2fft_pkg::LG_W'(1);
		else if (log_len_q > r2fft_pkg::LG_W'(r2fft_pkg::MAX_LOG_LEN))
			lg = r2fft_pkg::LG_W'(r2fft_pkg::MAX_LOG_LEN);
		else lg = log_len_q;
	end

	assign n_w         = CW'(1) << lg;
	assign half_w      = n_w >> 1;
	assign last_load   = (CW'(load_idx_q) + CW'(1)) >= n_w;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign post_needed = !inverse_q && shift_q;
	assign batch_eff   = (batch_q == '0) ? r2fft_pkg::BATCH_W'(1) : batch_q;
	assign rd_last_frame = (CW'(read_idx_q) + CW'(1)) >= n_w;
	assign rd_last_batch = rd_last_frame &&
		((frame_cnt_q + r2fft_pkg::BATCH_W'(1)) >= batch_eff);

	always_comb begin
		cnt_a = cnt_q[AW-1:0];
		for (int b = 0; b < AW; b++) rev_full[b] = cnt_a[AW-1-b];
		rev_sh = rev_full >> (r2fft_pkg::LG_W'(r2fft_pkg::MAX_LOG_LEN) - lg);
		span   = AW'(1) << stage_q;
		a_off  = cnt_a & (span - AW'(1));
		grp    = cnt_a >> stage_q;
		k_full = a_off << (r2fft_pkg::LG_W'(r2fft_pkg::ROM_AW) - stage_q);
		k      = k_full[r2fft_pkg::ROM_AW-1:0];
		pair_p = cnt_a;
		pair_q = cnt_a + half_w[AW-1:0];
		active = 1'b1;
		limit  = half_w;
		case (phase_q)
			r2fft_pkg::PH_BITREV: begin
				pair_q = rev_sh;
				active = cnt_a < rev_sh;
				limit  = n_w;
			end
			r2fft_pkg::PH_STAGE: begin
				pair_p = (grp << (stage_q + r2fft_pkg::LG_W'(1))) | a_off;
				pair_q = pair_p | span;
			end
			default: ;
		endcase
	end

	assign at_limit = (cnt_q == limit);
	assign xf_done  = at_limit && ((phase_q == r2fft_pkg::PH_POSTSWAP) ||
		((phase_q == r2fft_pkg::PH_STAGE) &&
		 (stage_q + r2fft_pkg::LG_W'(1) == lg) && !post_needed));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			r2fft_pkg::ST_IDLE: begin
				if (q_valid && !q_item.is_read && !frame_ready_q && last_load)
					state_d = r2fft_pkg::ST_XF_NEXT;
				else if (q_valid && q_item.is_read && out_free && frame_ready_q)
					state_d = r2fft_pkg::ST_RD_OUT;
			end
			r2fft_pkg::ST_RD_OUT:  if (out_free) state_d = r2fft_pkg::ST_IDLE;
			r2fft_pkg::ST_XF_NEXT: begin
				if (xf_done) state_d = r2fft_pkg::ST_IDLE;
				else if (!at_limit && active) state_d = r2fft_pkg::ST_XF_RD_P;
			end
			r2fft_pkg::ST_XF_RD_P: state_d = r2fft_pkg::ST_XF_RD_Q;
			r2fft_pkg::ST_XF_RD_Q: state_d = r2fft_pkg::ST_XF_MUL;
			r2fft_pkg::ST_XF_MUL:  state_d = r2fft_pkg::ST_XF_RND;
			r2fft_pkg::ST_XF_RND:  state_d = r2fft_pkg::ST_XF_WR_P;
			r2fft_pkg::ST_XF_WR_P: state_d = r2fft_pkg::ST_XF_WR_Q;
			r2fft_pkg::ST_XF_WR_Q: state_d = r2fft_pkg::ST_XF_NEXT;
			default:               state_d = r2fft_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop         = 1'b0;
		we            = 1'b0;
		waddr         = p_q;
		wdata         = {DW'(q_item.re), DW'(q_item.im)};
		raddr         = read_idx_q;
		out_load_nd   = 1'b0;
		out_load_data = 1'b0;
		case (state_q)
			r2fft_pkg::ST_IDLE: begin
				if (q_valid && !q_item.is_read) begin
					q_pop = 1'b1;
					if (!frame_ready_q) begin
						we    = 1'b1;
						waddr = load_idx_q;
					end
				end else if (q_valid && out_free) begin
					q_pop       = 1'b1;
					out_load_nd = !frame_ready_q;
				end
			end
			r2fft_pkg::ST_RD_OUT:  out_load_data = out_free;
			r2fft_pkg::ST_XF_RD_P: raddr = p_q;
			r2fft_pkg::ST_XF_RD_Q: raddr = q_q;
			r2fft_pkg::ST_XF_WR_P: begin
				we    = 1'b1;
				waddr = p_q;
				wdata = bfly_q ? {xp_re_q + t_re_q, xp_im_q + t_im_q} : {z_re_q, z_im_q};
			end
			r2fft_pkg::ST_XF_WR_Q: begin
				we    = 1'b1;
				waddr = q_q;
				wdata = bfly_q ? {xp_re_q - t_re_q, xp_im_q - t_im_q} : {xp_re_q, xp_im_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= r2fft_pkg::ST_IDLE;
			phase_q       <= r2fft_pkg::PH_BITREV;
			stage_q       <= '0;
			cnt_q         <= '0;
			log_len_q     <= r2fft_pkg::LG_W'(r2fft_pkg::MAX_LOG_LEN);
			inverse_q     <= 1'b0;
			shift_q       <= 1'b0;
			batch_q       <= r2fft_pkg::BATCH_W'(1);
			load_idx_q    <= '0;
			read_idx_q    <= '0;
			frame_cnt_q   <= '0;
			frame_ready_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					r2fft_pkg::CFG_LOG_LEN:      log_len_q <= cfg.data[r2fft_pkg::LG_W-1:0];
					r2fft_pkg::CFG_INVERSE:      inverse_q <= cfg.data[0];
					r2fft_pkg::CFG_SHIFT_HALVES: shift_q   <= cfg.data[0];
					r2fft_pkg::CFG_BATCH_FRAMES: batch_q   <= cfg.data;
					default: ;
				endcase
			end
			if (out_load_nd || out_load_data) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				r2fft_pkg::ST_IDLE: begin
					if (q_valid && !q_item.is_read && !frame_ready_q) begin
						if (last_load) begin
							load_idx_q <= '0;
							phase_q    <= (inverse_q && shift_q) ? r2fft_pkg::PH_PRESWAP
							                                    : r2fft_pkg::PH_BITREV;
							stage_q    <= '0;
							cnt_q      <= '0;
						end else begin
							load_idx_q <= load_idx_q + AW'(1);
						end
					end
				end
				r2fft_pkg::ST_RD_OUT: begin
					if (out_free) begin
						if (rd_last_frame) begin
							read_idx_q    <= '0;
							frame_ready_q <= 1'b0;
							frame_cnt_q   <= rd_last_batch ? '0
							                 : frame_cnt_q + r2fft_pkg::BATCH_W'(1);
						end else begin
							read_idx_q <= read_idx_q + AW'(1);
						end
					end
				end
				r2fft_pkg::ST_XF_NEXT: begin
					if (xf_done) begin
						frame_ready_q <= 1'b1;
					end else if (at_limit) begin
						cnt_q <= '0;
						case (phase_q)
							r2fft_pkg::PH_PRESWAP: phase_q <= r2fft_pkg::PH_BITREV;
							r2fft_pkg::PH_BITREV: begin
								phase_q <= r2fft_pkg::PH_STAGE;
								stage_q <= '0;
							end
							r2fft_pkg::PH_STAGE: begin
								if (stage_q + r2fft_pkg::LG_W'(1) == lg)
									phase_q <= r2fft_pkg::PH_POSTSWAP;
								else
									stage_q <= stage_q + r2fft_pkg::LG_W'(1);
							end
							default: ;
						endcase
					end else if (!active) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				r2fft_pkg::ST_XF_RD_P: cnt_q <= cnt_q + CW'(1);
				default: ;
			endcase
		end
	end

	assign sum_re = (r2fft_pkg::PROD_W+1)'(prr_q) - (r2fft_pkg::PROD_W+1)'(pii_q)
		+ (r2fft_pkg::PROD_W+1)'(1 << (r2fft_pkg::TW_FRAC - 1));
	assign sum_im = (r2fft_pkg::PROD_W+1)'(pri_q) + (r2fft_pkg::PROD_W+1)'(pir_q)
		+ (r2fft_pkg::PROD_W+1)'(1 << (r2fft_pkg::TW_FRAC - 1));

	// payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			r2fft_pkg::ST_XF_NEXT: begin
				p_q    <= pair_p;
				q_q    <= pair_q;
				bfly_q <= (phase_q == r2fft_pkg::PH_STAGE);
				wr_q   <= r2fft_pkg::ROM_COS[k];
				wi_q   <= inverse_q ? r2fft_pkg::ROM_SIN[k] : -r2fft_pkg::ROM_SIN[k];
			end
			r2fft_pkg::ST_XF_RD_Q: begin
				xp_re_q <= rdata_q[2*DW-1:DW];
				xp_im_q <= rdata_q[DW-1:0];
			end
			r2fft_pkg::ST_XF_MUL: begin
				z_re_q <= rdata_q[2*DW-1:DW];
				z_im_q <= rdata_q[DW-1:0];
				prr_q  <= wr_q * $signed(rdata_q[2*DW-1:DW]);
				pii_q  <= wi_q * $signed(rdata_q[DW-1:0]);
				pri_q  <= wr_q * $signed(rdata_q[DW-1:0]);
				pir_q  <= wi_q * $signed(rdata_q[2*DW-1:DW]);
			end
			r2fft_pkg::ST_XF_RND: begin
				t_re_q <= sum_re[r2fft_pkg::TW_FRAC +: DW];
				t_im_q <= sum_im[r2fft_pkg::TW_FRAC +: DW];
			end
			default: ;
		endcase
		if (out_load_nd) begin
			res_re_q <= '0;
			res_im_q <= '0;
			lf_q     <= 1'b0;
			lb_q     <= 1'b0;
			nd_q     <= 1'b1;
		end else if (out_load_data) begin
			res_re_q <= rdata_q[2*DW-1:DW];
			res_im_q <= rdata_q[DW-1:0];
			lf_q     <= rd_last_frame;
			lb_q     <= rd_last_batch;
			nd_q     <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.result_real   = res_re_q;
	assign out_ch.result_imag   = res_im_q;
	assign out_ch.last_in_frame = lf_q;
	assign out_ch.last_in_batch = lb_q;
	assign out_ch.no_data       = nd_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == r2fft_pkg::ST_IDLE) else $error("queue pop outside idle");
	a_xf_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == r2fft_pkg::ST_XF_MUL |-> !frame_ready_q)
		else $error("transform running on a finished frame");
	a_rd_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == r2fft_pkg::ST_RD_OUT |-> frame_ready_q)
		else $error("result read with no finished frame");
	a_nd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && nd_q |-> res_re_q == '0 && res_im_q == '0 && !lf_q && !lb_q)
		else $error("no_data word carries data");
	a_wrq_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == r2fft_pkg::ST_XF_WR_Q |-> $past(state_q) == r2fft_pkg::ST_XF_WR_P)
		else $error("second pair write without first");

endmodule

/* design/radix2_fft_frame_engine_core.sv */
// channel | dir | handshake   | word
// in_ch   | in  | valid/ready | mode, sample_real, sample_imag
// out_ch  | out | valid/ready | result_real, result_imag, last_in_frame, last_in_batch, no_data
// cfg     | in  | valid/ready | index, data (ready tied high)
//
// Sample write: taken and written to memory in the back end's idle state. Result read: the
// memory read is registered, then loaded into the result register. A frame-completing write
// runs the transform: each swap or butterfly steps through issue, two reads, multiply, round
// and two writes; a skipped bit-reverse index or a phase change takes only the issue state.
// The halves swap adds a swap pass over the frame.
// arst_n clears control, config to defaults; sample memory is not cleared.
// A 2-word queue decouples input from the back end; output stalls hold the result register.
module radix2_fft_frame_engine_core (
	input logic         clk,
	input logic         arst_n,
	r2fft_in_if.sink    in_ch,
	r2fft_out_if.source out_ch,
	r2fft_cfg_if.sink   cfg
);

	// front: accepts words and tags them write or read
	logic             q_valid;
	logic             q_pop;
	r2fft_pkg::item_t q_item;

	r2fft_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// back: sample memory, transform sequencer, result register
	r2fft_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.cfg     (cfg),
		.out_ch  (out_ch)
	);

endmodule

/* test/tb_r2fft_if.sv */
`timescale 1ns / 1ps
// No interfaces of its own here: the channel interfaces are taken from the design folder.
// This file holds the shared result word type used by the scoreboard.
package tb_r2fft_types;
	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               lf;
		logic               lb;
		logic               nd;
	} result_word_t;
endpackage

/* test/testbench.sv */
`timescale 1ns / 1ps
// Top level: drives the FFT engine through its word channels, predicts every
// result with a fixed-point model of its own and compares field by field.
module testbench;

	localparam int CYCLE_LIMIT = 4000000;

	// Expected-result store with its own copy of engine state.
	class fft_scoreboard;
		logic [31:0] mem_re [r2fft_pkg::FRAME_MAX];
		logic [31:0] mem_im [r2fft_pkg::FRAME_MAX];
		int unsigned lg_cfg, inv_cfg, shf_cfg, batch_cfg;
		int unsigned ld_idx, rd_idx, frm_cnt;
		bit ready_frame;
		tb_r2fft_types::result_word_t pending[$];
		int errors;
		int matched;
		longint cos_tab [r2fft_pkg::ROM_LEN];
		longint sin_tab [r2fft_pkg::ROM_LEN];

		function void init();
			lg_cfg = 10; inv_cfg = 0; shf_cfg = 0; batch_cfg = 1;
			ld_idx = 0; rd_idx = 0; frm_cnt = 0; ready_frame = 0;
			errors = 0; matched = 0;
			for (int k = 0; k < r2fft_pkg::ROM_LEN; k++) begin
				cos_tab[k] = longint'(r2fft_pkg::ROM_COS[k]);
				sin_tab[k] = longint'(r2fft_pkg::ROM_SIN[k]);
			end
		endfunction

		function void set_reg(logic [r2fft_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
			case (idx)
				r2fft_pkg::CFG_LOG_LEN:      lg_cfg = v & 4'hF;
				r2fft_pkg::CFG_INVERSE:      inv_cfg = v & 1;
				r2fft_pkg::CFG_SHIFT_HALVES: shf_cfg = v & 1;
				r2fft_pkg::CFG_BATCH_FRAMES: batch_cfg = v & 11'h7FF;
				default: ;
			endcase
		endfunction

		function void xchg(int unsigned a, int unsigned b);
			logic [31:0] t;
			t = mem_re[a]; mem_re[a] = mem_re[b]; mem_re[b] = t;
			t = mem_im[a]; mem_im[a] = mem_im[b]; mem_im[b] = t;
		endfunction

		// arithmetic shift of a 64-bit product equals floor division
		function logic [31:0] rnd(longint p);
			longint r;
			r = (p + (longint'(1) << (r2fft_pkg::TW_FRAC - 1))) >>> r2fft_pkg::TW_FRAC;
			return r[31:0];
		endfunction

		function void run_fft(int unsigned lg);
			int unsigned n, r, v, span, k;
			longint wr, wi, zr, zi;
			logic [31:0] tr, ti;
			n = 1 << lg;
			if (inv_cfg && shf_cfg)
				for (int i = 0; i < n / 2; i++) xchg(i, i + n / 2);
			for (int i = 0; i < n; i++) begin
				r = 0; v = i;
				for (int q = 0; q < lg; q++) begin
					r = (r << 1) | (v & 1); v >>= 1;
				end
				if (i < r) xchg(i, r);
			end
			for (int s = 0; s < lg; s++) begin
				span = 1 << s;
				for (int a = 0; a < span; a++) begin
					k = a << (r2fft_pkg::MAX_LOG_LEN - 1 - s);
					wr = cos_tab[k];
					wi = inv_cfg ? sin_tab[k] : -sin_tab[k];
					for (int b = 0; b < n; b += 2 * span) begin
						zr = longint'($signed(mem_re[b + a + span]));
						zi = longint'($signed(mem_im[b + a + span]));
						tr = rnd(wr * zr - wi * zi);
						ti = rnd(wr * zi + wi * zr);
						mem_re[b + a + span] = mem_re[b + a] - tr;
						mem_im[b + a + span] = mem_im[b + a] - ti;
						mem_re[b + a] = mem_re[b + a] + tr;
						mem_im[b + a] = mem_im[b + a] + ti;
					end
				end
			end
			if (!inv_cfg && shf_cfg)
				for (int i = 0; i < n / 2; i++) xchg(i, i + n / 2);
		endfunction

		// note an accepted input word
		function void note_word(bit rd, logic signed [15:0] re, logic signed [15:0] im);
			int unsigned lg, n, idx, bt;
			tb_r2fft_types::result_word_t w;
			lg = (lg_cfg < 1) ? 1 : (lg_cfg > r2fft_pkg::MAX_LOG_LEN ?
				r2fft_pkg::MAX_LOG_LEN : lg_cfg);
			n = 1 << lg;
			if (!rd) begin
				if (ready_frame) return;
				idx = ld_idx % r2fft_pkg::FRAME_MAX;
				mem_re[idx] = 32'(re);
				mem_im[idx] = 32'(im);
				if (idx + 1 >= n) begin
					run_fft(lg);
					ld_idx = 0;
					ready_frame = 1;
				end else ld_idx = idx + 1;
				return;
			end
			w = '{re: 0, im: 0, lf: 0, lb: 0, nd: 1};
			if (ready_frame) begin
				idx = rd_idx % r2fft_pkg::FRAME_MAX;
				bt = batch_cfg ? batch_cfg : 1;
				w.nd = 0;
				w.re = mem_re[idx];
				w.im = mem_im[idx];
				w.lf = (idx + 1 >= n);
				w.lb = w.lf && (frm_cnt + 1 >= bt);
				if (w.lf) begin
					rd_idx = 0;
					ready_frame = 0;
					frm_cnt = w.lb ? 0 : ((frm_cnt + 1) & 11'h7FF);
				end else rd_idx = idx + 1;
			end
			pending.push_back(w);
		endfunction

		task check_word(tb_r2fft_types::result_word_t got);
			tb_r2fft_types::result_word_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result word");
				return;
			end
			e = pending.pop_front();
			if (got.re !== e.re) report_mismatch($sformatf("real %0d want %0d", got.re, e.re));
			else if (got.im !== e.im)
				report_mismatch($sformatf("imag %0d want %0d", got.im, e.im));
			else if (got.lf !== e.lf || got.lb !== e.lb || got.nd !== e.nd)
				report_mismatch($sformatf("flags %b%b%b want %b%b%b",
					got.lf, got.lb, got.nd, e.lf, e.lb, e.nd));
			else matched++;
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask
	endclass

	logic clk;
	logic arst_n;
	r2fft_in_if  in_ch();
	r2fft_out_if out_ch();
	r2fft_cfg_if cfg();

	radix2_fft_frame_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	fft_scoreboard sb;
	int in_idle_pct;   // sender gap chance, percent
	int out_idle_pct;  // receiver stall chance, percent
	longint cycles;
	int sent_words;
	int frames_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// receiver: random ready at falling edge, sample at rising edge
	initial begin
		tb_r2fft_types::result_word_t got;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.re = out_ch.result_real;
				got.im = out_ch.result_imag;
				got.lf = out_ch.last_in_frame;
				got.lb = out_ch.last_in_batch;
				got.nd = out_ch.no_data;
				sb.check_word(got);
			end
		end
	end

	// one input word; valid held across back-to-back words, dropped only for a gap
	task automatic send_word(bit rd, logic signed [15:0] re, logic signed [15:0] im);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= rd;
		in_ch.sample_real <= re;
		in_ch.sample_imag <= im;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_word(rd, re, im);
		sent_words++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		// a trailing write may still be running a transform
		repeat (3 * 10 * r2fft_pkg::FRAME_MAX * 6 / 4 + 200) @(negedge clk);
	endtask

	task automatic write_reg(logic [r2fft_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= r2fft_pkg::CFG_DATA_W'(v);
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic setup(int unsigned lg, int unsigned inv, int unsigned shf, int unsigned bt);
		write_reg(r2fft_pkg::CFG_LOG_LEN, lg);
		write_reg(r2fft_pkg::CFG_INVERSE, inv);
		write_reg(r2fft_pkg::CFG_SHIFT_HALVES, shf);
		write_reg(r2fft_pkg::CFG_BATCH_FRAMES, bt);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rnd_sample();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// a full frame load then a full readback, with occasional noise
	task automatic frame_cycle(int unsigned n);
		for (int i = 0; i < n; i++) send_word(1'b0, rnd_sample(), rnd_sample());
		if ($urandom_range(3) == 0) send_word(1'b0, rnd_sample(), rnd_sample()); // ignored
		for (int i = 0; i < n; i++) send_word(1'b1, 16'sd0, 16'sd0);
		if ($urandom_range(3) == 0) send_word(1'b1, 16'sd0, 16'sd0);              // no data
		frames_done++;
	endtask

	task automatic random_phase(int words);
		int start;
		int unsigned lg;
		start = sent_words;
		while (sent_words - start < words) begin
			lg = sb.lg_cfg < 1 ? 1 : (sb.lg_cfg > r2fft_pkg::MAX_LOG_LEN ?
				r2fft_pkg::MAX_LOG_LEN : sb.lg_cfg);
			if ($urandom_range(9) == 0) send_word($urandom_range(1), rnd_sample(), rnd_sample());
			else frame_cycle(1 << lg);
		end
	endtask

	initial begin
		sb = new();
		sb.init();
		sent_words = 0;
		frames_done = 0;
		in_idle_pct = 18;
		out_idle_pct = 67;
		in_ch.valid = 1'b0;
		in_ch.mode = 1'b0;
		in_ch.sample_real = '0;
		in_ch.sample_imag = '0;
		cfg.valid = 1'b0;
		cfg.index = r2fft_pkg::CFG_LOG_LEN;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: read on empty engine, extremes, out-of-range settings
		send_word(1'b1, 16'sd0, 16'sd0);
		drain();
		setup(0, 0, 0, 0);                       // log length 0 acts as 1, batch 0 as 1
		send_word(1'b0, 16'sh7FFF, 16'sh8000);
		send_word(1'b0, 16'sh8000, 16'sh7FFF);
		send_word(1'b0, 16'sh1234, 16'sh1234);   // frame waiting: ignored
		send_word(1'b1, 16'sd0, 16'sd0);
		send_word(1'b1, 16'sd0, 16'sd0);
		send_word(1'b1, 16'sd0, 16'sd0);         // no data
		drain();
		setup(2, 1, 1, 2);
		frame_cycle(4);
		frame_cycle(4);
		drain();
		// above max acts as max length: a few writes must not end the frame
		setup(15, 0, 1, 1);
		for (int i = 0; i < 5; i++) send_word(1'b0, rnd_sample(), rnd_sample());
		drain();
		// shorter length mid-frame: next write passes the end
		write_reg(r2fft_pkg::CFG_LOG_LEN, 2);
		cfg.valid <= 1'b0;
		send_word(1'b0, 16'sh7FFF, 16'sh7FFF);
		for (int i = 0; i < 5; i++) send_word(1'b1, 16'sd0, 16'sd0);
		drain();

		// randomized phases with idling schedules
		setup(3, 0, 1, 3);
		random_phase(200);
		drain();
		setup(1, 1, 0, 1024);
		random_phase(150);
		// sender holds off until all results are back
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		random_phase(50);
		drain();
		in_idle_pct = 67; out_idle_pct = 18;
		setup(4, 1, 1, 2047);
		random_phase(250);
		drain();
		in_idle_pct = 0; out_idle_pct = 0;
		setup(5, 0, 0, 1);
		random_phase(300);
		drain();
		setup(2, 0, 1, 1);
		random_phase(100);
		drain();

		$display("run covered %0d input words, %0d frames, %0d results matched",
			sent_words, frames_done, sb.matched);
		$display("lengths 2..32 plus clamped settings, both directions, half swap, batches");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

/* filelist.f */
design/r2fft_pkg.sv
design/r2fft_if.sv
design/r2fft_front.sv
design/r2fft_engine.sv
design/radix2_fft_frame_engine_core.sv
test/tb_r2fft_if.sv
test/testbench.sv
